### rtl/core/wvm_pkg.sv
`timescale 1ns / 1ps

package wvm_pkg;

    localparam int NUM_TYPES         = 7;
    localparam int MAX_VOICES_DEF    = 16;
    localparam int BLOCK_SAMPLES_DEF = 512;
    localparam int WAVE_DEPTH_DEF    = 65536;
    localparam int MUSIC_GAIN        = 18000;
    localparam int FX_GAIN           = 6000;

    localparam int LEN_W      = 17;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;
    localparam int SAMPLE_W   = 16;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PLAY_ENABLES = 4'd7;
    localparam logic [1:0]           PLAY_EN_RESET    = 2'd3;

    localparam logic [1:0] RES_NONE    = 2'd0;
    localparam logic [1:0] RES_REFUSED = 2'd1;
    localparam logic [1:0] RES_TICK    = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       load_wr;
        logic       scan;
        logic       fx_kill;
        logic       acc_clr;
        logic       voice_go;
        logic       sc1;
        logic       sc2;
        logic       sc3;
        logic       res_load;
        logic [1:0] res_sel;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
    } status_t;

    function automatic logic [LEN_W-1:0] len_reset(input int t);
        logic [LEN_W-1:0] r;
        case (t)
            2:       r = 17'd13230;
            5:       r = 17'd61740;
            6:       r = 17'd35280;
            default: r = 17'd22050;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/wvm_in_if.sv
`timescale 1ns / 1ps

interface wvm_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [2:0]        sound_type;
    logic [15:0]       table_index;
    logic signed [15:0] table_sample;
    logic [15:0]       start_volume;
    logic signed [15:0] music_sample;

    modport source (output valid, kind, sound_type, table_index, table_sample,
                    start_volume, music_sample, input ready);
    modport sink   (input valid, kind, sound_type, table_index, table_sample,
                    start_volume, music_sample, output ready);
endinterface

### rtl/core/wvm_out_if.sv
`timescale 1ns / 1ps

interface wvm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] audio_out;
    logic               sample_valid;
    logic               start_refused;
    logic               clipped;

    modport source (output valid, audio_out, sample_valid, start_refused, clipped,
                    input ready);
    modport sink   (input valid, audio_out, sample_valid, start_refused, clipped,
                    output ready);
endinterface

### rtl/core/wvm_cfg_if.sv
`timescale 1ns / 1ps

interface wvm_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [16:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/wavetable_voice_mixer_core.sv
`timescale 1ns / 1ps

// Wavetable sound-effect mixer.
// in_ch carries one item per transfer: kind 0 writes one wavetable word, kind 1
// opens a voice in the lowest free slot, kind 2 mixes one output sample.
// Every accepted item yields exactly one transfer on out_ch; ticks set
// sample_valid, a start with all slots busy sets start_refused.
// cfg_ch writes the seven type lengths (index 0..6) and play_enables (index 7);
// write only while idle. cfg_ch is always ready.
// Steps: a load writes one word, a start scans slots from slot 0 (slot scan, one slot
// a cycle), a tick walks every voice slot (one voice slot a cycle through the
// wavetable read port and multiplier, then three scaling steps).
// One item is in work at a time; in_ch.ready is high only while idle.
// A finished result waits in the output register while the next item is
// accepted; if out_ch stalls, the following result holds until it drains.
// Reset frees all voices, restores register defaults and clears block phase;
// wavetable contents are undefined until loaded.

module wavetable_voice_mixer_core #(
    parameter int MAX_VOICES    = wvm_pkg::MAX_VOICES_DEF,
    parameter int BLOCK_SAMPLES = wvm_pkg::BLOCK_SAMPLES_DEF,
    parameter int WAVE_DEPTH    = wvm_pkg::WAVE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    wvm_in_if.sink    in_ch,
    wvm_out_if.source out_ch,
    wvm_cfg_if.sink   cfg_ch
);
    import wvm_pkg::*;

    localparam int VIW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

    cmd_t           cmd;
    status_t        status;
    logic [VIW-1:0] idx;

    assign cfg_ch.ready = 1'b1;

    wvm_ctrl #(
        .MAX_VOICES (MAX_VOICES),
        .VIW        (VIW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_ready      (in_ch.ready),
        .in_kind       (in_ch.kind),
        .in_sound_type (in_ch.sound_type),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .status        (status),
        .cmd           (cmd),
        .idx           (idx)
    );

    wvm_datapath #(
        .MAX_VOICES    (MAX_VOICES),
        .BLOCK_SAMPLES (BLOCK_SAMPLES),
        .WAVE_DEPTH    (WAVE_DEPTH),
        .VIW           (VIW)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .idx             (idx),
        .status          (status),
        .in_sound_type   (in_ch.sound_type),
        .in_table_index  (in_ch.table_index),
        .in_table_sample (in_ch.table_sample),
        .in_start_volume (in_ch.start_volume),
        .in_music_sample (in_ch.music_sample),
        .cfg_we          (cfg_ch.valid),
        .cfg_index       (cfg_ch.index),
        .cfg_data        (cfg_ch.data),
        .audio_out       (out_ch.audio_out),
        .sample_valid    (out_ch.sample_valid),
        .start_refused   (out_ch.start_refused),
        .clipped         (out_ch.clipped)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input accepted while an item is in work");

    a_one_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.sample_valid && out_ch.start_refused))
        else $error("result flagged as both tick and refused start");

    a_clip_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.clipped) |-> out_ch.sample_valid)
        else $error("clip flag on a non-tick result");

endmodule

### rtl/core/wvm_ram.sv
`timescale 1ns / 1ps

module wvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/wvm_ctrl.sv
`timescale 1ns / 1ps

module wvm_ctrl #(
    parameter int MAX_VOICES = 16,
    parameter int VIW        = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_kind,
    input  logic [2:0]       in_sound_type,
    output logic             out_valid,
    input  logic             out_ready,
    input  wvm_pkg::status_t status,
    output wvm_pkg::cmd_t    cmd,
    output logic [VIW-1:0]   idx
);
    import wvm_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_KILL  = 4'd3;
    localparam logic [3:0] S_VOICE = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_SC1   = 4'd6;
    localparam logic [3:0] S_SC2   = 4'd7;
    localparam logic [3:0] S_SC3   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam logic [VIW-1:0] LAST_IDX = VIW'(MAX_VOICES - 1);

    logic [3:0]     state_reg, state_next;
    logic [VIW-1:0] idx_reg, idx_next;
    logic [1:0]     res_reg, res_next;
    logic           drain_reg, drain_next;
    logic           out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign idx       = idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res_sel    = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    res_next    = RES_NONE;
                    idx_next    = '0;
                    case (in_kind)
                        KIND_LOAD:  state_next = S_LOAD;
                        KIND_START: state_next = (int'(in_sound_type) < NUM_TYPES) ?
                                                 S_SCAN : S_DONE;
                        KIND_TICK:  state_next = S_KILL;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.load_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.slot_free)
                begin
                    state_next = S_DONE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    res_next   = RES_REFUSED;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_KILL:
            begin
                cmd.fx_kill = 1'b1;
                cmd.acc_clr = 1'b1;
                state_next  = S_VOICE;
            end
            S_VOICE:
            begin
                cmd.voice_go = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    drain_next = 1'b0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = S_SC1;
                end
            end
            S_SC1:
            begin
                cmd.sc1    = 1'b1;
                state_next = S_SC2;
            end
            S_SC2:
            begin
                cmd.sc2    = 1'b1;
                state_next = S_SC3;
            end
            S_SC3:
            begin
                cmd.sc3    = 1'b1;
                res_next   = RES_TICK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            res_reg       <= RES_NONE;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            res_reg       <= res_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/wvm_datapath.sv
`timescale 1ns / 1ps

module wvm_datapath #(
    parameter int MAX_VOICES    = 16,
    parameter int BLOCK_SAMPLES = 512,
    parameter int WAVE_DEPTH    = 65536,
    parameter int VIW           = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wvm_pkg::cmd_t                 cmd,
    input  logic [VIW-1:0]                idx,
    output wvm_pkg::status_t              status,
    input  logic [2:0]                    in_sound_type,
    input  logic [15:0]                   in_table_index,
    input  logic signed [15:0]            in_table_sample,
    input  logic [15:0]                   in_start_volume,
    input  logic signed [15:0]            in_music_sample,
    input  logic                          cfg_we,
    input  logic [wvm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wvm_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic signed [15:0]            audio_out,
    output logic                          sample_valid,
    output logic                          start_refused,
    output logic                          clipped
);
    import wvm_pkg::*;

    localparam int RAM_DEPTH = NUM_TYPES * WAVE_DEPTH;
    localparam int RAW       = $clog2(RAM_DEPTH);
    localparam int PW        = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam int AW        = $clog2(MAX_VOICES) + 34;
    localparam int TW        = AW + 16;
    localparam int QW        = TW - 31;
    localparam logic [PW-1:0]    LAST_PHASE = PW'(BLOCK_SAMPLES - 1);
    localparam logic [LEN_W-1:0] BS_L       = LEN_W'(BLOCK_SAMPLES);
    localparam logic [17:0]      WD_L       = 18'(WAVE_DEPTH);

    logic [LEN_W-1:0] len_reg [NUM_TYPES];
    logic [1:0]       en_reg;

    logic [MAX_VOICES-1:0] active_reg;
    logic [MAX_VOICES-1:0] wait_reg;
    logic [2:0]            kind_reg [MAX_VOICES];
    logic [15:0]           pos_reg  [MAX_VOICES];
    logic [15:0]           gain_reg [MAX_VOICES];
    logic [PW-1:0]         phase_reg;

    logic [2:0]         type_reg;
    logic [15:0]        tidx_reg;
    logic signed [15:0] tsample_reg;
    logic [15:0]        volume_reg;
    logic signed [15:0] music_reg;

    logic               s1_vld_reg, s1_use_reg, s2_vld_reg;
    logic [15:0]        s1_gain_reg;
    logic signed [32:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW+14:0] fxm_reg;
    logic signed [31:0] mm_reg;
    logic signed [TW-1:0] total_reg;
    logic signed [15:0] tick_audio;
    logic               tick_clip;
    logic signed [15:0] audio_hold;
    logic               clip_hold;

    logic               v_act, v_wait, v_kvalid, v_retire, v_playing, v_inrange;
    logic               boundary, last_tick;
    logic [2:0]         v_kind;
    logic [15:0]        v_pos;
    logic [LEN_W-1:0]   v_len;
    logic [16:0]        v_ridx;
    logic [31:0]        v_addr;
    logic [31:0]        w_addr;
    logic               ram_we;
    logic [15:0]        ram_rdata;
    logic [TW-1:0]      mag;
    logic [QW-1:0]      q;

    assign boundary  = (phase_reg == '0);
    assign last_tick = (phase_reg == LAST_PHASE);
    assign v_act     = active_reg[idx];
    assign v_wait    = wait_reg[idx];
    assign v_kind    = kind_reg[idx];
    assign v_pos     = pos_reg[idx];
    assign v_kvalid  = (int'(v_kind) < NUM_TYPES);
    assign v_len     = v_kvalid ? len_reg[v_kind] : '0;
    assign v_retire  = !v_kvalid || (({1'b0, v_pos} + BS_L) >= v_len);
    assign v_playing = v_act && (boundary ? !v_retire : !v_wait);
    assign v_ridx    = {1'b0, v_pos} + 17'(phase_reg);
    assign v_inrange = v_kvalid && ({1'b0, v_ridx} < WD_L);
    assign v_addr    = 32'(v_kind) * 32'(WAVE_DEPTH) + 32'(v_ridx);
    assign w_addr    = 32'(type_reg) * 32'(WAVE_DEPTH) + 32'(tidx_reg);
    assign ram_we    = cmd.load_wr && (int'(type_reg) < NUM_TYPES) &&
                       ({2'b00, tidx_reg} < WD_L);

    assign status.slot_free = !active_reg[idx];

    wvm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_wave_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (w_addr[RAW-1:0]),
        .wdata (tsample_reg),
        .raddr (v_addr[RAW-1:0]),
        .rdata (ram_rdata)
    );

    assign mag = total_reg[TW-1] ? (TW'(0) - total_reg) : total_reg;
    assign q   = mag[TW-1:31];

    always_comb
    begin
        if (total_reg[TW-1])
        begin
            tick_clip  = (q > QW'(32768));
            tick_audio = tick_clip ? 16'sh8000 : 16'(16'd0 - q[15:0]);
        end
        else
        begin
            tick_clip  = (q > QW'(32767));
            tick_audio = tick_clip ? 16'sh7FFF : q[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NUM_TYPES; t++)
            begin
                len_reg[t] <= len_reset(t);
            end
            en_reg <= PLAY_EN_RESET;
        end
        else if (cfg_we)
        begin
            if (int'(cfg_index) < NUM_TYPES)
            begin
                len_reg[cfg_index[2:0]] <= cfg_data;
            end
            else if (cfg_index == REG_PLAY_ENABLES)
            begin
                en_reg <= cfg_data[1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            wait_reg   <= '0;
            phase_reg  <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.voice_go;
            s2_vld_reg <= s1_vld_reg;
            if (cmd.scan && !active_reg[idx])
            begin
                active_reg[idx] <= 1'b1;
                wait_reg[idx]   <= 1'b1;
            end
            if (cmd.fx_kill && !en_reg[1])
            begin
                active_reg <= '0;
                wait_reg   <= '0;
            end
            if (cmd.voice_go && boundary && v_act)
            begin
                wait_reg[idx] <= 1'b0;
                if (v_retire)
                begin
                    active_reg[idx] <= 1'b0;
                end
            end
            if (cmd.sc3)
            begin
                phase_reg <= last_tick ? '0 : phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg    <= in_sound_type;
            tidx_reg    <= in_table_index;
            tsample_reg <= in_table_sample;
            volume_reg  <= in_start_volume;
            music_reg   <= in_music_sample;
        end
        if (cmd.scan && !active_reg[idx])
        begin
            kind_reg[idx] <= type_reg;
            pos_reg[idx]  <= '0;
            gain_reg[idx] <= volume_reg;
        end
        if (cmd.voice_go && last_tick && v_playing)
        begin
            pos_reg[idx] <= v_pos + BS_L[15:0];
        end
        s1_use_reg  <= v_playing && v_inrange;
        s1_gain_reg <= gain_reg[idx];
        prod_reg    <= s1_use_reg ? ($signed({1'b0, s1_gain_reg}) * $signed(ram_rdata)) :
                       33'sd0;
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
        if (cmd.sc1)
        begin
            fxm_reg <= acc_reg * $signed({1'b0, 14'(FX_GAIN)});
            mm_reg  <= music_reg * $signed(16'(MUSIC_GAIN));
        end
        if (cmd.sc2)
        begin
            total_reg <= (en_reg[1] ? TW'(fxm_reg) : TW'(0)) +
                         (en_reg[0] ? (TW'(mm_reg) <<< 16) : TW'(0));
        end
        if (cmd.res_load)
        begin
            audio_out     <= (cmd.res_sel == RES_TICK) ? audio_hold : 16'sd0;
            sample_valid  <= (cmd.res_sel == RES_TICK);
            start_refused <= (cmd.res_sel == RES_REFUSED);
            clipped       <= (cmd.res_sel == RES_TICK) && clip_hold;
        end
        if (cmd.sc3)
        begin
            audio_hold <= tick_audio;
            clip_hold  <= tick_clip;
        end
    end

endmodule
